>>> hdl/complex_int_power_square_multiply_defines.svh
// assertion macros for the complex integer power block
`ifndef COMPLEX_INT_POWER_SQUARE_MULTIPLY_DEFINES_SVH
`define COMPLEX_INT_POWER_SQUARE_MULTIPLY_DEFINES_SVH

`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define CPOW_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked on every clock edge, reset included
`define CPOW_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define CPOW_ASSERT_CLK(lbl, prop, msg)
`define CPOW_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> hdl/cpow_pkg.sv
// types, constants and microcode rom for the complex integer power block
package cpow_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 30;
   localparam int POWER_W    = 32;
   localparam int PROD_W     = 2 * DATA_WIDTH;
   localparam int SUM_W      = PROD_W + 1;
   localparam int HEAD_W     = SUM_W - DATA_WIDTH + 1;
   localparam int TDATA_W    = 2 * DATA_WIDTH;
   localparam int PC_W       = 4;

   localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic UNIT_SAT = (FRAC_BITS >= DATA_WIDTH - 1);
   localparam logic signed [DATA_WIDTH-1:0] UNIT_RE =
      UNIT_SAT ? D_MAX : (DATA_WIDTH'(1) << FRAC_BITS);
   localparam logic [POWER_W-1:0] POWER_RESET = POWER_W'(1);

   // program steps
   localparam logic [PC_W-1:0] STEP_ACCEPT    = 4'd0;
   localparam logic [PC_W-1:0] STEP_TEST_ZERO = 4'd1;
   localparam logic [PC_W-1:0] STEP_TEST_BIT  = 4'd2;
   localparam logic [PC_W-1:0] STEP_SHIFT     = 4'd8;
   localparam logic [PC_W-1:0] STEP_SPARE     = 4'd14;
   localparam logic [PC_W-1:0] STEP_EMIT      = 4'd15;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL,
      OP_MUL_LOAD,
      OP_MUL_SUB,
      OP_WR_R,
      OP_WR_B,
      OP_SHIFT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      SEL_R_RE,
      SEL_R_IM,
      SEL_B_RE,
      SEL_B_IM
   } asel_type;

   typedef enum logic {
      SEL_BASE_RE,
      SEL_BASE_IM
   } bsel_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_INPUT,
      C_P_ZERO,
      C_P_EVEN,
      C_P_LAST,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type    op;
      asel_type  a_sel;
      bsel_type  b_sel;
      cond_type  cond;
      logic [PC_W-1:0] target;
   } ctrl_word_type;

   typedef struct packed {
      op_type    op;
      asel_type  a_sel;
      bsel_type  b_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic p_zero;
      logic p_even;
      logic p_last;
   } dp_status_type;

   function automatic ctrl_word_type mk(op_type op, asel_type a, bsel_type b,
                                        cond_type c, logic [PC_W-1:0] t);
      ctrl_word_type w;
      w.op     = op;
      w.a_sel  = a;
      w.b_sel  = b;
      w.cond   = c;
      w.target = t;
      return w;
   endfunction

   // one control word per step; a taken condition jumps, otherwise step + 1
   function automatic ctrl_word_type program_rom(logic [PC_W-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         4'd0:    w = mk(OP_LOAD,     SEL_R_RE, SEL_BASE_RE, C_NO_INPUT, STEP_ACCEPT);
         4'd1:    w = mk(OP_NOP,      SEL_R_RE, SEL_BASE_RE, C_P_ZERO,   STEP_EMIT);
         4'd2:    w = mk(OP_NOP,      SEL_R_RE, SEL_BASE_RE, C_P_EVEN,   STEP_SHIFT);
         // result times base
         4'd3:    w = mk(OP_MUL,      SEL_R_RE, SEL_BASE_RE, C_NEXT,     STEP_ACCEPT);
         4'd4:    w = mk(OP_MUL_LOAD, SEL_R_IM, SEL_BASE_IM, C_NEXT,     STEP_ACCEPT);
         4'd5:    w = mk(OP_MUL_SUB,  SEL_R_RE, SEL_BASE_IM, C_NEXT,     STEP_ACCEPT);
         4'd6:    w = mk(OP_MUL_LOAD, SEL_R_IM, SEL_BASE_RE, C_NEXT,     STEP_ACCEPT);
         4'd7:    w = mk(OP_WR_R,     SEL_R_RE, SEL_BASE_RE, C_NEXT,     STEP_ACCEPT);
         4'd8:    w = mk(OP_SHIFT,    SEL_R_RE, SEL_BASE_RE, C_P_LAST,   STEP_EMIT);
         // base squared
         4'd9:    w = mk(OP_MUL,      SEL_B_RE, SEL_BASE_RE, C_NEXT,     STEP_ACCEPT);
         4'd10:   w = mk(OP_MUL_LOAD, SEL_B_IM, SEL_BASE_IM, C_NEXT,     STEP_ACCEPT);
         4'd11:   w = mk(OP_MUL_SUB,  SEL_B_RE, SEL_BASE_IM, C_NEXT,     STEP_ACCEPT);
         4'd12:   w = mk(OP_MUL_LOAD, SEL_B_IM, SEL_BASE_RE, C_NEXT,     STEP_ACCEPT);
         4'd13:   w = mk(OP_WR_B,     SEL_R_RE, SEL_BASE_RE, C_ALWAYS,   STEP_TEST_ZERO);
         4'd14:   w = mk(OP_NOP,      SEL_R_RE, SEL_BASE_RE, C_ALWAYS,   STEP_ACCEPT);
         4'd15:   w = mk(OP_EMIT,     SEL_R_RE, SEL_BASE_RE, C_OUT_BUSY, STEP_EMIT);
         default: w = mk(OP_NOP,      SEL_R_RE, SEL_BASE_RE, C_ALWAYS,   STEP_ACCEPT);
      endcase
      return w;
   endfunction

endpackage

>>> hdl/cpow_datapath.sv
// shared complex multiply datapath: one real multiplier, accumulator and narrowing
module cpow_datapath (
   input  logic                                  clock,
   input  cpow_pkg::dp_cmd_type                  cmd,
   input  logic signed [cpow_pkg::DATA_WIDTH-1:0] base_re,
   input  logic signed [cpow_pkg::DATA_WIDTH-1:0] base_im,
   input  logic                                  end_of_vector,
   input  logic [cpow_pkg::POWER_W-1:0]          power,
   output cpow_pkg::dp_status_type               status,
   output logic signed [cpow_pkg::DATA_WIDTH-1:0] out_re,
   output logic signed [cpow_pkg::DATA_WIDTH-1:0] out_im,
   output logic                                  overflow,
   output logic                                  end_marker
);

   logic signed [cpow_pkg::DATA_WIDTH-1:0] b_re_ff, b_re_in, b_im_ff, b_im_in;
   logic signed [cpow_pkg::DATA_WIDTH-1:0] r_re_ff, r_re_in, r_im_ff, r_im_in;
   logic signed [cpow_pkg::DATA_WIDTH-1:0] t_re_ff, t_re_in;
   logic signed [cpow_pkg::PROD_W-1:0]     prod_ff, prod_in, acc_ff, acc_in;
   logic [cpow_pkg::POWER_W-1:0]           p_ff, p_in;
   logic                                   flag_ff, flag_in, last_ff, last_in;

   logic signed [cpow_pkg::DATA_WIDTH-1:0] mul_a, mul_b;
   logic signed [cpow_pkg::PROD_W-1:0]     mul_p;
   logic signed [cpow_pkg::SUM_W-1:0]      acc_x, prod_x, sum, shifted;
   logic [cpow_pkg::HEAD_W-1:0]            head;
   logic                                   fits;
   logic signed [cpow_pkg::DATA_WIDTH-1:0] narrow;

   always_comb begin
      unique case (cmd.a_sel)
         cpow_pkg::SEL_R_RE: mul_a = r_re_ff;
         cpow_pkg::SEL_R_IM: mul_a = r_im_ff;
         cpow_pkg::SEL_B_RE: mul_a = b_re_ff;
         cpow_pkg::SEL_B_IM: mul_a = b_im_ff;
         default:            mul_a = r_re_ff;
      endcase
      mul_b = (cmd.b_sel == cpow_pkg::SEL_BASE_IM) ? b_im_ff : b_re_ff;
   end

   assign mul_p = mul_a * mul_b;

   // exact sum of two products, then arithmetic shift and range check
   assign acc_x   = $signed({acc_ff[cpow_pkg::PROD_W-1], acc_ff});
   assign prod_x  = $signed({prod_ff[cpow_pkg::PROD_W-1], prod_ff});
   assign sum     = (cmd.op == cpow_pkg::OP_MUL_SUB) ? acc_x - prod_x : acc_x + prod_x;
   assign shifted = sum >>> cpow_pkg::FRAC_BITS;
   assign head    = shifted[cpow_pkg::SUM_W-1 -: cpow_pkg::HEAD_W];
   assign fits    = (head == '0) || (head == '1);
   assign narrow  = fits ? shifted[cpow_pkg::DATA_WIDTH-1:0]
                         : (sum[cpow_pkg::SUM_W-1] ? cpow_pkg::D_MIN : cpow_pkg::D_MAX);

   always_comb begin
      b_re_in = b_re_ff;
      b_im_in = b_im_ff;
      r_re_in = r_re_ff;
      r_im_in = r_im_ff;
      t_re_in = t_re_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      p_in    = p_ff;
      flag_in = flag_ff;
      last_in = last_ff;
      unique case (cmd.op)
         cpow_pkg::OP_LOAD: begin
            b_re_in = base_re;
            b_im_in = base_im;
            r_re_in = cpow_pkg::UNIT_RE;
            r_im_in = '0;
            p_in    = power;
            flag_in = cpow_pkg::UNIT_SAT;
            last_in = end_of_vector;
         end
         cpow_pkg::OP_MUL: begin
            prod_in = mul_p;
         end
         cpow_pkg::OP_MUL_LOAD: begin
            prod_in = mul_p;
            acc_in  = prod_ff;
         end
         cpow_pkg::OP_MUL_SUB: begin
            prod_in = mul_p;
            t_re_in = narrow;
            flag_in = flag_ff | ~fits;
         end
         cpow_pkg::OP_WR_R: begin
            r_re_in = t_re_ff;
            r_im_in = narrow;
            flag_in = flag_ff | ~fits;
         end
         cpow_pkg::OP_WR_B: begin
            b_re_in = t_re_ff;
            b_im_in = narrow;
            flag_in = flag_ff | ~fits;
         end
         cpow_pkg::OP_SHIFT: begin
            p_in = p_ff >> 1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      b_re_ff <= b_re_in;
      b_im_ff <= b_im_in;
      r_re_ff <= r_re_in;
      r_im_ff <= r_im_in;
      t_re_ff <= t_re_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      p_ff    <= p_in;
      flag_ff <= flag_in;
      last_ff <= last_in;
   end

   assign status.p_zero = (p_ff == '0);
   assign status.p_even = ~p_ff[0];
   assign status.p_last = (p_ff[cpow_pkg::POWER_W-1:1] == '0);

   assign out_re     = r_re_ff;
   assign out_im     = r_im_ff;
   assign overflow   = flag_ff;
   assign end_marker = last_ff;

endmodule

>>> hdl/complex_int_power_square_multiply.sv
// complex element raised to a configured power: microcode sequencer and output stage
// one item at a time: a new item is taken only in the accept step, after the
//    previous result has gone to the output stage; each complex product takes
//    five steps of the single shared 32x32 multiplier, driven by a 16-step
//    microcode rom
// reset: synchronous, returns the step counter to accept, empties the output stage
//    and sets power to 1
`include "complex_int_power_square_multiply_defines.svh"

module complex_int_power_square_multiply (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cpow_pkg::TDATA_W-1:0]     req_tdata,  // base_re, base_im
   input  logic                             req_tlast,  // end_of_vector
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cpow_pkg::TDATA_W-1:0]     rsp_tdata,  // out_re, out_im
   output logic                             rsp_tuser,  // overflow
   output logic                             rsp_tlast,  // end_marker
   input  logic                             csr_wr_en,
   input  logic [cpow_pkg::POWER_W-1:0]     csr_wr_data
);

   logic [cpow_pkg::PC_W-1:0]    pc_ff, pc_in;
   logic [cpow_pkg::POWER_W-1:0] power_ff, power_in;
   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [cpow_pkg::TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic                         rsp_tuser_ff, rsp_tuser_in;
   logic                         rsp_tlast_ff, rsp_tlast_in;

   cpow_pkg::ctrl_word_type  ctrl;
   cpow_pkg::dp_cmd_type     cmd;
   cpow_pkg::dp_status_type  status;
   logic signed [cpow_pkg::DATA_WIDTH-1:0] dp_re, dp_im;
   logic                     dp_ovf, dp_last;
   logic                     out_busy, take, emit_fire;

   assign ctrl     = cpow_pkg::program_rom(pc_ff);
   assign out_busy = rsp_tvalid_ff & ~rsp_tready;

   always_comb begin
      unique case (ctrl.cond)
         cpow_pkg::C_NEXT:     take = 1'b0;
         cpow_pkg::C_ALWAYS:   take = 1'b1;
         cpow_pkg::C_NO_INPUT: take = ~req_tvalid;
         cpow_pkg::C_P_ZERO:   take = status.p_zero;
         cpow_pkg::C_P_EVEN:   take = status.p_even;
         cpow_pkg::C_P_LAST:   take = status.p_last;
         cpow_pkg::C_OUT_BUSY: take = out_busy;
         default:              take = 1'b1;
      endcase
   end

   assign pc_in      = take ? ctrl.target : pc_ff + 1'b1;
   assign req_tready = (ctrl.op == cpow_pkg::OP_LOAD);
   assign emit_fire  = (ctrl.op == cpow_pkg::OP_EMIT) & ~out_busy;

   // the load step only acts on an item actually taken
   always_comb begin
      cmd.op    = ctrl.op;
      cmd.a_sel = ctrl.a_sel;
      cmd.b_sel = ctrl.b_sel;
      if ((ctrl.op == cpow_pkg::OP_LOAD) && !req_tvalid) begin
         cmd.op = cpow_pkg::OP_NOP;
      end
   end

   cpow_datapath u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .base_re       ($signed(req_tdata[cpow_pkg::DATA_WIDTH-1:0])),
      .base_im       ($signed(req_tdata[cpow_pkg::TDATA_W-1:cpow_pkg::DATA_WIDTH])),
      .end_of_vector (req_tlast),
      .power         (power_ff),
      .status        (status),
      .out_re        (dp_re),
      .out_im        (dp_im),
      .overflow      (dp_ovf),
      .end_marker    (dp_last)
   );

   assign power_in = csr_wr_en ? csr_wr_data : power_ff;

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;
      if (emit_fire) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {dp_im, dp_re};
         rsp_tuser_in  = dp_ovf;
         rsp_tlast_in  = dp_last;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= cpow_pkg::STEP_ACCEPT;
         power_ff      <= cpow_pkg::POWER_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         power_ff      <= power_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   `CPOW_ASSERT_RST(a_reset_idle, reset |=> (pc_ff == cpow_pkg::STEP_ACCEPT) && !rsp_tvalid_ff, "reset did not return to accept step")
   `CPOW_ASSERT_CLK(a_load_starts, (req_tvalid && req_tready) |=> (pc_ff == cpow_pkg::STEP_TEST_ZERO), "accepted item did not start the exponent loop")
   `CPOW_ASSERT_CLK(a_emit_done, emit_fire |=> rsp_tvalid_ff && (pc_ff == cpow_pkg::STEP_ACCEPT), "emitted item not held or sequencer not back at accept")
   `CPOW_ASSERT_CLK(a_spare_step, (pc_ff == cpow_pkg::STEP_SPARE) |=> (pc_ff == cpow_pkg::STEP_ACCEPT), "spare step not left at once")

endmodule
